// ----- hw/rtl/vidm_pkg.sv -----
// ----------------------------------------------------------------------------
// vidm_pkg
// Shared constants, widths and types of the inverse distance mean unit.
// ----------------------------------------------------------------------------
package vidm_pkg;

    // Sizing
    localparam int MAX_SAMPLES = 256;
    localparam int BIN_RANGE   = 256;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    // Field widths
    localparam int BIN_W   = 8;
    localparam int POS_W   = 19;
    localparam int SHIFT_W = 16;
    localparam int STEP_W  = 16;
    localparam int OUT_W   = 16;
    localparam int BINC_W  = 13;

    // Distance path
    localparam int GRID_W = 26;
    localparam int AD_W   = 25;
    localparam int SQ_W   = 2 * AD_W;
    localparam int D2_W   = SQ_W + 2;

    // Weights and sums
    localparam int W_W   = 24;
    localparam int WT_W  = W_W + CNT_W;
    localparam int ST_W  = SHIFT_W + W_W + CNT_W;
    localparam int A2_W  = 2 * SHIFT_W;
    localparam int P_W   = A2_W + W_W;
    localparam int Q_W   = P_W + CNT_W;

    // Divider and root units
    localparam int DIVN_W = Q_W;
    localparam int DIVD_W = D2_W;
    localparam int DIVC_W = $clog2(DIVN_W + 1);
    localparam int SQI_W  = 48;
    localparam int SQO_W  = SQI_W / 2;
    localparam int SQC_W  = $clog2(SQO_W + 1);
    localparam int WGT_SHIFT = 48;

    // Configuration port
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 19;
    localparam logic [CFG_A_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_STEP_X   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_STEP_Y   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_STEP_Z   = 3'd5;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int RAM_W = 3 * SHIFT_W + W_W;

    typedef struct packed {
        logic [2:0][SHIFT_W-1:0] shift;
        logic [W_W-1:0]          weight;
        logic                    last;
        logic                    empty;
    } vidm_item_t;

endpackage

// ----- hw/rtl/vidm_ram.sv -----
// ----------------------------------------------------------------------------
// vidm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vidm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/vidm_div.sv -----
// ----------------------------------------------------------------------------
// vidm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vidm_div
    import vidm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [DIVD_W-1:0] divisor,
    output logic              done,
    output logic [DIVN_W-1:0] quotient
);

    logic [DIVN_W-1:0] num_reg, num_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] den_reg, den_next;
    logic [DIVC_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVD_W:0]   trial;
    logic              fits;

    always_comb
    begin
        trial     = {rem_reg, num_reg[DIVN_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = DIVC_W'(DIVN_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract where the divisor fits
            rem_next = fits ? DIVD_W'(trial - {1'b0, den_reg}) : trial[DIVD_W-1:0];
            num_next = {num_reg[DIVN_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIVC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ----- hw/rtl/vidm_isqrt.sv -----
// ----------------------------------------------------------------------------
// vidm_isqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module vidm_isqrt
    import vidm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SQI_W-1:0] radicand,
    output logic             done,
    output logic [SQO_W-1:0] root
);

    logic [SQI_W-1:0]   rad_reg, rad_next;
    logic [SQO_W+1:0]   rem_reg, rem_next;
    logic [SQO_W-1:0]   root_reg, root_next;
    logic [SQC_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SQO_W+1:0]   pend;
    logic [SQO_W+1:0]   trial;

    always_comb
    begin
        pend      = {rem_reg[SQO_W-1:0], rad_reg[SQI_W-1:SQI_W-2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = SQC_W'(SQO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // bring down two radicand bits, try the next root bit
            rad_next = {rad_reg[SQI_W-3:0], 2'b00};
            if (pend >= trial)
            begin
                rem_next  = pend - trial;
                root_next = {root_reg[SQO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = pend;
                root_next = {root_reg[SQO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SQC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- hw/rtl/vidm_fifo.sv -----
// ----------------------------------------------------------------------------
// vidm_fifo
// Short request queue between the weight front end and the accumulator.
// ----------------------------------------------------------------------------
module vidm_fifo
    import vidm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  vidm_item_t push_item,
    output logic       full,
    input  logic       pop,
    output vidm_item_t pop_item,
    output logic       empty
);

    vidm_item_t         slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   fill_reg, fill_next;
    logic               do_push, do_pop;

    assign full     = (fill_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/vidm_front.sv -----
// ----------------------------------------------------------------------------
// vidm_front
// Accept samples, hold the grid registers, compute the inverse distance weight.
// ----------------------------------------------------------------------------
module vidm_front
    import vidm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_A_W-1:0]        cfg_addr,
    input  logic [CFG_D_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0][BIN_W-1:0]     in_bin,
    input  logic [2:0][POS_W-1:0]     in_pos,
    input  logic [2:0][SHIFT_W-1:0]   in_shift,
    input  logic                      in_last,
    input  logic                      in_empty,
    output logic                      push,
    output vidm_item_t                push_item,
    input  logic                      full
);

    localparam logic [3:0] F_IDLE  = 4'd0;
    localparam logic [3:0] F_DIST  = 4'd1;
    localparam logic [3:0] F_SQR   = 4'd2;
    localparam logic [3:0] F_ACC   = 4'd3;
    localparam logic [3:0] F_DIV   = 4'd4;
    localparam logic [3:0] F_DWAIT = 4'd5;
    localparam logic [3:0] F_SWAIT = 4'd6;
    localparam logic [3:0] F_PUSH  = 4'd7;

    logic [3:0]                state_reg, state_next;
    logic [1:0]                k_reg, k_next;
    logic [2:0][POS_W-1:0]     origin_reg;
    logic [2:0][STEP_W-1:0]    step_reg;
    logic [2:0][BIN_W-1:0]     bin_reg, bin_next;
    logic [2:0][POS_W-1:0]     pos_reg, pos_next;
    vidm_item_t                item_reg, item_next;
    logic [AD_W-1:0]           ad_reg, ad_next;
    logic [SQ_W-1:0]           sq_reg, sq_next;
    logic [D2_W-1:0]           d2_reg, d2_next;

    logic [BIN_W-1:0]          bin_sel, bin_clamped;
    logic [STEP_W+BIN_W-1:0]   cell_off;
    logic signed [GRID_W-1:0]  grid, delta;
    logic [DIVN_W-1:0]         div_q;
    logic                      div_done, div_start;
    logic [SQI_W-1:0]          rad;
    logic                      sq_start, sq_done;
    logic [SQO_W-1:0]          sq_root;

    // grid point minus sample position on the current axis
    always_comb
    begin
        bin_sel     = bin_reg[k_reg];
        bin_clamped = ({{(BINC_W-BIN_W){1'b0}}, bin_sel} >= BINC_W'(BIN_RANGE))
                      ? BIN_W'(BIN_RANGE - 1) : bin_sel;
        cell_off    = step_reg[k_reg] * bin_clamped;
        grid        = GRID_W'($signed(origin_reg[k_reg]))
                      + $signed({{(GRID_W-STEP_W-BIN_W){1'b0}}, cell_off});
        delta       = grid - GRID_W'($signed(pos_reg[k_reg]));
    end

    assign div_start = (state_reg == F_DIV);
    assign rad       = (|div_q[DIVN_W-1:SQI_W]) ? {SQI_W{1'b1}} : div_q[SQI_W-1:0];
    assign sq_start  = (state_reg == F_DWAIT) && div_done;
    assign in_ready  = (state_reg == F_IDLE);
    assign push      = (state_reg == F_PUSH);
    assign push_item = item_reg;

    vidm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DIVN_W'(1) << WGT_SHIFT),
        .divisor  (d2_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    vidm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        bin_next   = bin_reg;
        pos_next   = pos_reg;
        item_next  = item_reg;
        ad_next    = ad_reg;
        sq_next    = sq_reg;
        d2_next    = d2_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    bin_next        = in_bin;
                    pos_next        = in_pos;
                    item_next.shift = in_shift;
                    item_next.last  = in_last;
                    item_next.empty = in_empty;
                    k_next          = '0;
                    d2_next         = '0;
                    state_next      = in_empty ? F_PUSH : F_DIST;
                end
            end
            F_DIST:
            begin
                ad_next    = delta[GRID_W-1] ? AD_W'(-delta) : AD_W'(delta);
                state_next = F_SQR;
            end
            F_SQR:
            begin
                sq_next    = ad_reg * ad_reg;
                state_next = F_ACC;
            end
            F_ACC:
            begin
                d2_next = d2_reg + D2_W'(sq_reg);
                if (k_reg == 2'd2)
                begin
                    state_next = F_DIV;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = F_DIST;
                end
            end
            F_DIV:
            begin
                state_next = F_DWAIT;
            end
            F_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = F_SWAIT;
                end
            end
            F_SWAIT:
            begin
                if (sq_done)
                begin
                    // raise a vanishing weight to one
                    item_next.weight = (sq_root == '0) ? W_W'(1) : sq_root;
                    state_next       = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            k_reg      <= '0;
            origin_reg <= '0;
            step_reg   <= {3{STEP_W'(64)}};
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                    REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                    REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                    REG_STEP_X:   step_reg[0]   <= cfg_data[STEP_W-1:0];
                    REG_STEP_Y:   step_reg[1]   <= cfg_data[STEP_W-1:0];
                    REG_STEP_Z:   step_reg[2]   <= cfg_data[STEP_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        pos_reg  <= pos_next;
        item_reg <= item_next;
        ad_reg   <= ad_next;
        sq_reg   <= sq_next;
        d2_reg   <= d2_next;
    end

endmodule

// ----- hw/rtl/vidm_back.sv -----
// ----------------------------------------------------------------------------
// vidm_back
// Accumulate weighted samples, store them, and on the last sample compute
// mean and deviation per axis into the output register.
// ----------------------------------------------------------------------------
module vidm_back
    import vidm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fifo_empty,
    input  vidm_item_t             fifo_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0][OUT_W-1:0]  out_mean,
    output logic [2:0][OUT_W-1:0]  out_spread,
    output logic                   out_is_empty,
    output logic                   out_overflowed
);

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_MUL   = 4'd1;
    localparam logic [3:0] B_MEAN  = 4'd2;
    localparam logic [3:0] B_MWAIT = 4'd3;
    localparam logic [3:0] B_RD    = 4'd4;
    localparam logic [3:0] B_SQ    = 4'd5;
    localparam logic [3:0] B_MW    = 4'd6;
    localparam logic [3:0] B_AC    = 4'd7;
    localparam logic [3:0] B_QDIV  = 4'd8;
    localparam logic [3:0] B_QWAIT = 4'd9;
    localparam logic [3:0] B_SWAIT = 4'd10;
    localparam logic [3:0] B_EMIT  = 4'd11;

    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     drop_reg, drop_next;
    logic [WT_W-1:0]          wtot_reg, wtot_next;
    logic [2:0][ST_W-1:0]     stot_reg, stot_next;
    vidm_item_t               it_reg, it_next;
    logic [1:0]               k_reg, k_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [OUT_W-1:0]         mean_reg, mean_next;
    logic [A2_W-1:0]          a2_reg, a2_next;
    logic [P_W-1:0]           p_reg, p_next;
    logic [Q_W-1:0]           q_reg, q_next;
    logic [2:0][OUT_W-1:0]    res_mean_reg, res_mean_next;
    logic [2:0][OUT_W-1:0]    res_spread_reg, res_spread_next;
    logic                     res_empty_reg, res_empty_next;
    logic                     ov_reg, ov_next;
    logic [2:0][OUT_W-1:0]    om_reg, om_next;
    logic [2:0][OUT_W-1:0]    os_reg, os_next;
    logic                     oe_reg, oe_next;
    logic                     oo_reg, oo_next;

    logic                     ram_we, ram_re;
    logic [RAM_W-1:0]         ram_wdata, ram_rdata;
    logic [SHIFT_W-1:0]       ram_shift;
    logic [W_W-1:0]           ram_weight;
    logic                     div_start, div_done;
    logic [DIVN_W-1:0]        div_n, div_q;
    logic [DIVD_W-1:0]        div_d;
    logic                     sq_start, sq_done;
    logic [SQI_W-1:0]         sq_rad;
    logic [SQO_W-1:0]         sq_root;
    logic signed [ST_W-1:0]   sum_sel;
    logic [ST_W-1:0]          mag;
    logic signed [SHIFT_W+W_W:0] wprod;
    logic signed [SHIFT_W:0]  diff;
    logic [SHIFT_W-1:0]       adiff;
    logic                     room, has_room;

    assign room      = !ov_reg || out_ready;
    assign has_room  = (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign pop       = (state_reg == B_IDLE) && !fifo_empty;
    assign ram_we    = pop && !fifo_item.empty && has_room;
    assign ram_wdata = {fifo_item.weight, fifo_item.shift};
    assign ram_re    = (state_reg == B_RD);
    assign ram_weight = ram_rdata[RAM_W-1 -: W_W];
    assign ram_shift  = ram_rdata[k_reg*SHIFT_W +: SHIFT_W];

    vidm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (j_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // one divider serves the mean and the variance
    always_comb
    begin
        sum_sel = $signed(stot_reg[k_reg]);
        mag     = sum_sel[ST_W-1] ? ST_W'(-sum_sel) : ST_W'(sum_sel);
        if (state_reg == B_MEAN)
        begin
            div_n = DIVN_W'({mag, 1'b0}) + DIVN_W'(wtot_reg);
            div_d = DIVD_W'({wtot_reg, 1'b0});
        end
        else
        begin
            div_n = DIVN_W'(q_reg);
            div_d = DIVD_W'(wtot_reg);
        end
    end

    assign div_start = (state_reg == B_MEAN) || (state_reg == B_QDIV);
    assign sq_start  = (state_reg == B_QWAIT) && div_done;
    assign sq_rad    = (|div_q[DIVN_W-1:32]) ? SQI_W'(32'hFFFF_FFFF) : SQI_W'(div_q[31:0]);

    vidm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    vidm_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        wprod = $signed(it_reg.shift[k_reg]) * $signed({1'b0, it_reg.weight});
        diff  = (SHIFT_W+1)'($signed(ram_shift)) - (SHIFT_W+1)'($signed(mean_reg));
        adiff = diff[SHIFT_W] ? SHIFT_W'(-diff) : SHIFT_W'(diff);
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        drop_next       = drop_reg;
        wtot_next       = wtot_reg;
        stot_next       = stot_reg;
        it_next         = it_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        mean_next       = mean_reg;
        a2_next         = a2_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        res_mean_next   = res_mean_reg;
        res_spread_next = res_spread_reg;
        res_empty_next  = res_empty_reg;
        ov_next         = ov_reg;
        om_next         = om_reg;
        os_next         = os_reg;
        oe_next         = oe_reg;
        oo_next         = oo_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    it_next        = fifo_item;
                    k_next         = '0;
                    res_empty_next = fifo_item.empty;
                    if (fifo_item.empty)
                    begin
                        state_next = B_EMIT;
                    end
                    else if (has_room)
                    begin
                        state_next = B_MUL;
                    end
                    else
                    begin
                        // store full: drop the sample, still close on last
                        drop_next  = 1'b1;
                        state_next = fifo_item.last ? B_MEAN : B_IDLE;
                    end
                end
            end
            B_MUL:
            begin
                stot_next[k_reg] = stot_reg[k_reg] + ST_W'(wprod);
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    cnt_next   = cnt_reg + 1'b1;
                    wtot_next  = wtot_reg + WT_W'(it_reg.weight);
                    state_next = it_reg.last ? B_MEAN : B_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            B_MEAN:
            begin
                state_next = B_MWAIT;
            end
            B_MWAIT:
            begin
                if (div_done)
                begin
                    // round half away from zero, then saturate
                    if (!sum_sel[ST_W-1])
                    begin
                        mean_next = (div_q > DIVN_W'(32767)) ? 16'h7FFF : div_q[OUT_W-1:0];
                    end
                    else
                    begin
                        mean_next = (div_q > DIVN_W'(32768)) ? 16'h8000
                                    : OUT_W'(~div_q[OUT_W-1:0] + 1'b1);
                    end
                    j_next     = '0;
                    q_next     = '0;
                    state_next = B_RD;
                end
            end
            B_RD:
            begin
                state_next = B_SQ;
            end
            B_SQ:
            begin
                a2_next    = adiff * adiff;
                state_next = B_MW;
            end
            B_MW:
            begin
                p_next     = a2_reg * ram_weight;
                state_next = B_AC;
            end
            B_AC:
            begin
                q_next = q_reg + Q_W'(p_reg);
                if ((j_reg + 1'b1) == cnt_reg)
                begin
                    state_next = B_QDIV;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            B_QDIV:
            begin
                state_next = B_QWAIT;
            end
            B_QWAIT:
            begin
                if (div_done)
                begin
                    state_next = B_SWAIT;
                end
            end
            B_SWAIT:
            begin
                if (sq_done)
                begin
                    res_mean_next[k_reg]   = mean_reg;
                    res_spread_next[k_reg] = sq_root[OUT_W-1:0];
                    if (k_reg == 2'd2)
                    begin
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = B_MEAN;
                    end
                end
            end
            B_EMIT:
            begin
                if (room)
                begin
                    ov_next    = 1'b1;
                    om_next    = res_empty_reg ? '0 : res_mean_reg;
                    os_next    = res_empty_reg ? '0 : res_spread_reg;
                    oe_next    = res_empty_reg;
                    oo_next    = res_empty_reg ? 1'b0 : drop_reg;
                    cnt_next   = '0;
                    drop_next  = 1'b0;
                    wtot_next  = '0;
                    stot_next  = '0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            wtot_reg  <= '0;
            stot_reg  <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            wtot_reg  <= wtot_next;
            stot_reg  <= stot_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg         <= it_next;
        mean_reg       <= mean_next;
        a2_reg         <= a2_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        res_mean_reg   <= res_mean_next;
        res_spread_reg <= res_spread_next;
        res_empty_reg  <= res_empty_next;
        om_reg         <= om_next;
        os_reg         <= os_next;
        oe_reg         <= oe_next;
        oo_reg         <= oo_next;
    end

    assign out_valid      = ov_reg;
    assign out_mean       = om_reg;
    assign out_spread     = os_reg;
    assign out_is_empty   = oe_reg;
    assign out_overflowed = oo_reg;

endmodule

// ----- hw/rtl/voxel_inverse_distance_mean_unit.sv -----
// ----------------------------------------------------------------------------
// voxel_inverse_distance_mean_unit
// Inverse distance weighted mean and standard deviation of the displacement
// samples of one voxel.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  sample: bins, position, shift;
//                                          s_tlast = last sample,
//                                          s_tuser = empty voxel
//   m_*      out        m_tvalid/m_tready  mean, spread; m_tuser = flags
//   cfg_*    in         cfg_we only        origin and step registers
//
// The front end takes one request at a time: it does the distance math per
// axis (states F_DIST, F_SQR, F_ACC), starts its restoring divider, waits
// on the divider and then on the root unit, and pushes the weight before it
// takes the next request. The back end stores and sums each sample per axis.
// Closing a voxel takes, per axis, two divisions and a root plus a second
// pass over the samples stored in the sample RAM.
// A four entry queue lets the front end keep weighing while the back end
// closes a voxel or waits on m_tready; the result register frees the back
// end once m_tready is seen. Reset clears all control state.
// ----------------------------------------------------------------------------
module voxel_inverse_distance_mean_unit
    import vidm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [CFG_D_W-1:0] cfg_data,
    // samples
    input  logic               s_tvalid,
    output logic               s_tready,
    // bin_x, bin_y, bin_z, pos_x, pos_y, pos_z, shift_x, shift_y, shift_z
    input  logic [135:0]       s_tdata,
    input  logic               s_tlast,
    // empty_voxel
    input  logic               s_tuser,
    // results
    output logic               m_tvalid,
    input  logic               m_tready,
    // mean_x, mean_y, mean_z, spread_x, spread_y, spread_z
    output logic [95:0]        m_tdata,
    // is_empty, overflowed
    output logic [1:0]         m_tuser
);

    logic [2:0][BIN_W-1:0]   in_bin;
    logic [2:0][POS_W-1:0]   in_pos;
    logic [2:0][SHIFT_W-1:0] in_shift;
    logic                    push, full, pop, fifo_empty;
    vidm_item_t              push_item, pop_item;
    logic [2:0][OUT_W-1:0]   out_mean, out_spread;
    logic                    out_is_empty, out_overflowed;

    // unpack the sample request
    assign in_bin   = s_tdata[23:0];
    assign in_pos   = s_tdata[80:24];
    assign in_shift = s_tdata[128:81];

    vidm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_bin    (in_bin),
        .in_pos    (in_pos),
        .in_shift  (in_shift),
        .in_last   (s_tlast),
        .in_empty  (s_tuser),
        .push      (push),
        .push_item (push_item),
        .full      (full)
    );

    vidm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (fifo_empty)
    );

    vidm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_empty     (fifo_empty),
        .fifo_item      (pop_item),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_mean       (out_mean),
        .out_spread     (out_spread),
        .out_is_empty   (out_is_empty),
        .out_overflowed (out_overflowed)
    );

    // pack the result request
    assign m_tdata = {out_spread, out_mean};
    assign m_tuser = {out_overflowed, out_is_empty};

endmodule

// ----- dv/tb_voxel_inverse_distance_mean_unit.sv -----
// ----------------------------------------------------------------------------
// tb_voxel_inverse_distance_mean_unit
// Self-checking bench for the inverse distance weighted mean unit: drives
// voxel sample streams through several grid settings, predicts the mean and
// spread of every closed voxel in a scoreboard and compares each result.
// ----------------------------------------------------------------------------
module tb_voxel_inverse_distance_mean_unit;
    import vidm_pkg::*;

    localparam int WATCH_LIMIT = 20000;   // cycles without any handshake
    localparam int DRAIN_WAIT  = 400;     // settle time after the last result
    localparam longint unsigned WEIGHT_MAX = 64'd16777215;

    typedef struct {
        logic [BIN_W-1:0]   bin[3];
        logic [POS_W-1:0]   pos[3];
        logic [SHIFT_W-1:0] shift[3];
        logic               last;
        logic               empty;
    } sample_t;

    typedef struct {
        logic [OUT_W-1:0] mean[3];
        logic [OUT_W-1:0] spread[3];
        logic             is_empty;
        logic             overflowed;
    } voxel_stat_t;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: owns a copy of the grid registers and the voxel
    // accumulation, predicts one result per closed voxel.
    // ------------------------------------------------------------------------
    class voxel_stat_scoreboard;
        longint          origin[3];
        longint          step[3];
        logic [SHIFT_W-1:0] shift_mem[MAX_SAMPLES][3];
        longint unsigned weight_mem[MAX_SAMPLES];
        longint unsigned weight_sum;
        longint          wshift_sum[3];
        int              count;
        bit              dropped;
        voxel_stat_t     pending[$];
        int              errors;

        function void clear_voxel();
            weight_sum = 0;
            for (int k = 0; k < 3; k++)
                wshift_sum[k] = 0;
            count = 0;
            dropped = 0;
        endfunction

        function void reset_regs();
            for (int k = 0; k < 3; k++)
            begin
                origin[k] = 0;
                step[k] = 64;
            end
            errors = 0;
            clear_voxel();
        endfunction

        function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
            if (idx <= REG_ORIGIN_Z)
                origin[idx] = longint'($signed(val));
            else if (idx <= REG_STEP_Z)
                step[idx - REG_STEP_X] = longint'(val[STEP_W-1:0]);
        endfunction

        function longint grid(int k, logic [BIN_W-1:0] bin);
            return origin[k] + step[k] * longint'(bin);
        endfunction

        function void note_request(sample_t s);
            voxel_stat_t     r;
            longint unsigned d2;
            longint unsigned w;
            longint unsigned mag;
            longint unsigned q;
            longint unsigned a;
            longint          d;
            longint          mean;
            logic [127:0]    sq_sum;
            logic [127:0]    quo;
            if (s.empty)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    r.mean[k] = '0;
                    r.spread[k] = '0;
                end
                r.is_empty = 1;
                r.overflowed = 0;
                pending.insert(pending.size(), r);
                clear_voxel();
                return;
            end
            // weight from squared distance to the grid point
            d2 = 0;
            for (int k = 0; k < 3; k++)
            begin
                d = grid(k, s.bin[k]) - longint'($signed(s.pos[k]));
                a = (d < 0) ? longint'(-d) : longint'(d);
                d2 += a * a;
            end
            if (d2 == 0)
                w = WEIGHT_MAX;
            else
            begin
                w = int_sqrt((64'd1 << 48) / d2);
                if (w > WEIGHT_MAX)
                    w = WEIGHT_MAX;
                if (w == 0)
                    w = 1;
            end
            if (count < MAX_SAMPLES)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    shift_mem[count][k] = s.shift[k];
                    wshift_sum[k] += longint'($signed(s.shift[k])) * longint'(w);
                end
                weight_mem[count] = w;
                weight_sum += w;
                count++;
            end
            else
                dropped = 1;
            if (!s.last)
                return;
            // close the voxel: rounded mean, then spread around it
            for (int k = 0; k < 3; k++)
            begin
                mag = (wshift_sum[k] < 0) ? longint'(-wshift_sum[k]) : wshift_sum[k];
                q = (2 * mag + weight_sum) / (2 * weight_sum);
                mean = (wshift_sum[k] < 0) ? -longint'(q) : longint'(q);
                if (mean > 32767)
                    mean = 32767;
                if (mean < -32768)
                    mean = -32768;
                sq_sum = '0;
                for (int j = 0; j < count; j++)
                begin
                    d = longint'($signed(shift_mem[j][k])) - mean;
                    a = (d < 0) ? longint'(-d) : longint'(d);
                    sq_sum += 128'(a * a * weight_mem[j]);
                end
                quo = sq_sum / 128'(weight_sum);
                q = int_sqrt(quo[63:0]);
                r.mean[k] = mean[OUT_W-1:0];
                r.spread[k] = (q > 65535) ? 16'hFFFF : q[OUT_W-1:0];
            end
            r.is_empty = 0;
            r.overflowed = dropped;
            pending.insert(pending.size(), r);
            clear_voxel();
        endfunction

        function void check(voxel_stat_t got);
            voxel_stat_t e;
            string       ax;
            if (pending.size() == 0)
            begin
                $error("result with no voxel pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < 3; k++)
            begin
                ax = (k == 0) ? "x" : (k == 1) ? "y" : "z";
                if (got.mean[k] !== e.mean[k])
                begin
                    $error("mean_%s expected %0d got %0d", ax,
                           $signed(e.mean[k]), $signed(got.mean[k]));
                    errors++;
                end
                if (got.spread[k] !== e.spread[k])
                begin
                    $error("spread_%s expected %0d got %0d", ax, e.spread[k], got.spread[k]);
                    errors++;
                end
            end
            if (got.is_empty !== e.is_empty)
            begin
                $error("is_empty expected %0d got %0d", e.is_empty, got.is_empty);
                errors++;
            end
            if (got.overflowed !== e.overflowed)
            begin
                $error("overflowed expected %0d got %0d", e.overflowed, got.overflowed);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CFG_A_W-1:0] cfg_addr;
    logic [CFG_D_W-1:0] cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [135:0]       s_tdata;   // bin_x/y/z, pos_x/y/z, shift_x/y/z
    logic               s_tlast;
    logic               s_tuser;   // empty_voxel
    logic               m_tvalid;
    logic               m_tready;
    logic [95:0]        m_tdata;   // mean_x/y/z, spread_x/y/z
    logic [1:0]         m_tuser;   // is_empty, overflowed

    voxel_stat_scoreboard sb;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;
    int  sent;

    voxel_inverse_distance_mean_unit u_top (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    // Sample the result handshake with the values from before this edge.
    always @(posedge clk)
    begin
        voxel_stat_t got;
        if (m_tvalid && m_tready)
        begin
            for (int k = 0; k < 3; k++)
            begin
                got.mean[k]   = m_tdata[16*k +: 16];
                got.spread[k] = m_tdata[48 + 16*k +: 16];
            end
            got.is_empty   = m_tuser[0];
            got.overflowed = m_tuser[1];
            sb.check(got);
        end
        if (hold_req && hold_left == 0)
            hold_left <= 4000;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        if (hold_left > 1 || (hold_req && hold_left == 0))
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCH_LIMIT)
        begin
            $display("[voxel_inverse_distance_mean_unit] ERROR");
            $finish;
        end
    end

    // Offer one request; hold tvalid high across back-to-back requests.
    task automatic send_request(sample_t s);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, s.shift[2], s.shift[1], s.shift[0],
                     s.pos[2], s.pos[1], s.pos[0], s.bin[2], s.bin[1], s.bin[0]};
        s_tlast  <= s.last;
        s_tuser  <= s.empty;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(s);
        sent++;
    endtask

    // Pulse the write enable for one cycle and drop it again before returning.
    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Let every expected result come out, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] clamp_pos(longint p);
        if (p > 262143)
            return 19'h3FFFF;
        if (p < -262144)
            return 19'h40000;
        return p[POS_W-1:0];
    endfunction

    // Build a sample; place it near the grid point most of the time.
    function automatic sample_t make_sample(logic [BIN_W-1:0] b[3], bit last);
        sample_t s;
        int      kind;
        int      span;
        kind = $urandom_range(99);
        span = 1 << $urandom_range(0, 14);
        for (int k = 0; k < 3; k++)
        begin
            s.bin[k] = b[k];
            if (kind < 10)
                s.pos[k] = clamp_pos(sb.grid(k, b[k]));
            else if (kind < 80)
                s.pos[k] = clamp_pos(sb.grid(k, b[k]) + $urandom_range(0, 2*span) - span);
            else
                s.pos[k] = POS_W'($urandom);
            s.shift[k] = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 1024) - 512);
        end
        s.last = last;
        s.empty = 0;
        return s;
    endfunction

    function automatic sample_t empty_sample();
        sample_t s;
        for (int k = 0; k < 3; k++)
        begin
            s.bin[k] = BIN_W'($urandom);
            s.pos[k] = POS_W'($urandom);
            s.shift[k] = SHIFT_W'($urandom);
        end
        s.last = 1'($urandom);
        s.empty = 1;
        return s;
    endfunction

    // One voxel of n samples; mostly shared bins, sometimes an empty
    // marker breaks into the middle of the stream.
    task automatic run_voxel(int n, bit allow_empty = 1'b1);
        logic [BIN_W-1:0] b[3];
        for (int k = 0; k < 3; k++)
            b[k] = BIN_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 10)
                for (int k = 0; k < 3; k++)
                    b[k] = BIN_W'($urandom);
            if (allow_empty && i > 0 && $urandom_range(99) < 2)
                send_request(empty_sample());
            send_request(make_sample(b, i == n - 1));
        end
    endtask

    task automatic random_traffic(int quota, bit with_overflow);
        int goal;
        goal = sent + quota;
        if (with_overflow)
            run_voxel(MAX_SAMPLES + 4, 1'b0);
        while (sent < goal)
        begin
            if ($urandom_range(99) < 6)
                send_request(empty_sample());
            else if ($urandom_range(99) < 10)
                run_voxel($urandom_range(9, 40));
            else
                run_voxel($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        sample_t          s;
        logic [BIN_W-1:0] b[3];
        sb = new();
        sb.reset_regs();
        sent = 0;
        quiet_cycles = 0;
        hold_req = 0;
        hold_left = 0;
        snd_idle_pct = 9;
        rcv_idle_pct = 84;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset grid: zero distance at the origin bin
        b = '{8'd0, 8'd0, 8'd0};
        s = make_sample(b, 1);
        s.pos = '{19'd0, 19'd0, 19'd0};
        s.shift = '{16'h7FFF, 16'h8000, 16'd0};
        send_request(s);
        // extremes of bins, positions and shifts in one voxel
        b = '{8'hFF, 8'hFF, 8'hFF};
        s = make_sample(b, 0);
        s.pos = '{19'h3FFFF, 19'h40000, 19'h3FFFF};
        s.shift = '{16'h8000, 16'h8000, 16'h8000};
        send_request(s);
        s.pos = '{19'h40000, 19'h3FFFF, 19'h40000};
        s.shift = '{16'h7FFF, 16'h7FFF, 16'h7FFF};
        send_request(s);
        s = make_sample(b, 1);
        s.pos = '{19'h7FFFF, 19'h7FFFF, 19'h7FFFF};
        send_request(s);
        // empty voxel alone, then one that cuts a voxel short
        send_request(empty_sample());
        send_request(make_sample(b, 0));
        send_request(make_sample(b, 0));
        send_request(empty_sample());
        // single samples of mixed bins
        for (int i = 0; i < 6; i++)
        begin
            for (int k = 0; k < 3; k++)
                b[k] = BIN_W'($urandom);
            send_request(make_sample(b, 1));
        end
        random_traffic(380, 0);
        drain();

        // Extreme grid: far corner, widest step; far samples weigh 1
        snd_idle_pct = 84;
        rcv_idle_pct = 9;
        write_reg(REG_ORIGIN_X, 19'h3FFFF);
        write_reg(REG_ORIGIN_Y, 19'h3FFFF);
        write_reg(REG_ORIGIN_Z, 19'h3FFFF);
        write_reg(REG_STEP_X, 19'hFFFF);
        write_reg(REG_STEP_Y, 19'hFFFF);
        write_reg(REG_STEP_Z, 19'hFFFF);
        b = '{8'hFF, 8'hFF, 8'hFF};
        s = make_sample(b, 0);
        s.pos = '{19'h40000, 19'h40000, 19'h40000};
        send_request(s);
        s.last = 1;
        send_request(s);
        random_traffic(400, 0);
        drain();

        // Lowest origin, zero and unit steps; includes a store overflow
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(REG_ORIGIN_X, 19'h40000);
        write_reg(REG_ORIGIN_Y, 19'h40000);
        write_reg(REG_ORIGIN_Z, 19'h40000);
        write_reg(REG_STEP_X, 19'd0);
        write_reg(REG_STEP_Y, 19'd1);
        write_reg(REG_STEP_Z, 19'($urandom_range(1, 65535)));
        random_traffic(400, 1);
        drain();

        // Moderate grid; receiver holds off long enough to back up input
        write_reg(REG_ORIGIN_X, 19'($urandom_range(0, 8192) - 4096));
        write_reg(REG_ORIGIN_Y, 19'($urandom_range(0, 8192) - 4096));
        write_reg(REG_ORIGIN_Z, 19'($urandom_range(0, 8192) - 4096));
        write_reg(REG_STEP_X, 19'($urandom_range(16, 256)));
        write_reg(REG_STEP_Y, 19'($urandom_range(16, 256)));
        write_reg(REG_STEP_Z, 19'($urandom_range(16, 256)));
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        random_traffic(400, 0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[voxel_inverse_distance_mean_unit] OK");
        else
            $display("[voxel_inverse_distance_mean_unit] ERROR");
        $finish;
    end

endmodule
